[rtl/efa_pkg.sv]
// ----------------------------------------------------------------------------
// efa_pkg: shared constants and types of the exact-fit free-list allocator
// Sizes of the heap, the free table and the header store, command and status
// codes, plus the request and response types of the shared arithmetic unit.
// ----------------------------------------------------------------------------
package efa_pkg;

	localparam int HEAP_WORDS = 4096;
	localparam int FREE_DEPTH = 256;

	localparam int OFF_W   = 15;                        // offsets, sizes, heap byte counts
	localparam int ALU_W   = 16;                        // rounded sizes reach 2**15
	localparam int HDR_AW  = $clog2(HEAP_WORDS);        // header store address
	localparam int FREE_AW = $clog2(FREE_DEPTH);        // free table address
	localparam int CNT_W   = $clog2(FREE_DEPTH + 1);    // free table fill count
	localparam int FREE_DW = 2 * OFF_W;                 // {offset, size}

	localparam logic [OFF_W-1:0] HEAP_CAP = OFF_W'(HEAP_WORDS * 4);

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	typedef enum logic [2:0] {
		ST_FRESH     = 3'd0,
		ST_REUSED    = 3'd1,
		ST_EXHAUSTED = 3'd2,
		ST_FREED     = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef enum logic {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		alu_op_t           op;
		logic [ALU_W-1:0]  a;
		logic [ALU_W-1:0]  b;
	} alu_req_t;

	typedef struct packed {
		logic [ALU_W:0]    y;
		logic              zero;
		logic              borrow;
	} alu_rsp_t;

endpackage

[rtl/efa_if.sv]
// ----------------------------------------------------------------------------
// efa_if: valid/ready channels of the exact-fit free-list allocator
// Command, response and configuration write channels.
// ----------------------------------------------------------------------------
interface efa_cmd_if;
	logic                        valid;
	logic                        ready;
	logic                        command;
	logic [efa_pkg::OFF_W-1:0]   request_size;
	logic [efa_pkg::OFF_W-1:0]   block_offset;

	modport source (output valid, command, request_size, block_offset, input ready);
	modport sink   (input valid, command, request_size, block_offset, output ready);
endinterface

interface efa_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [efa_pkg::OFF_W-1:0]   result_offset;
	logic [2:0]                  status;

	modport source (output valid, result_offset, status, input ready);
	modport sink   (input valid, result_offset, status, output ready);
endinterface

interface efa_cfg_if;
	logic                        valid;
	logic                        ready;
	logic [efa_pkg::OFF_W-1:0]   data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

[rtl/efa_ram.sv]
// ----------------------------------------------------------------------------
// efa_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module efa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/efa_alu.sv]
// ----------------------------------------------------------------------------
// efa_alu: shared add/subtract/compare unit
// One add or subtract per cycle with zero and borrow flags.
// ----------------------------------------------------------------------------
module efa_alu (
	input  efa_pkg::alu_req_t req,
	output efa_pkg::alu_rsp_t rsp
);

	logic [efa_pkg::ALU_W:0] sum;

	always_comb begin
		unique case (req.op)
			efa_pkg::ALU_ADD: sum = {1'b0, req.a} + {1'b0, req.b};
			efa_pkg::ALU_SUB: sum = {1'b0, req.a} - {1'b0, req.b};
			default:          sum = '0;
		endcase
	end

	assign rsp.y      = sum;
	assign rsp.zero   = (sum[efa_pkg::ALU_W-1:0] == '0);
	assign rsp.borrow = (req.op == efa_pkg::ALU_SUB) && sum[efa_pkg::ALU_W];

endmodule

[rtl/exact_fit_free_list_allocator_core.sv]
// ----------------------------------------------------------------------------
// exact_fit_free_list_allocator_core: bump allocator with exact-fit free list
// Sequencer around one shared adder, a free table RAM and a header RAM.
// ----------------------------------------------------------------------------
// Usage:
//   cmd  - one transfer per command. command 0 allocates request_size bytes
//          (rounded up to a multiple of 4, zero taken as 4); command 1 frees
//          the block whose content starts at block_offset.
//   rsp  - exactly one transfer per command: result_offset and status
//          (0 fresh, 1 reused, 2 heap exhausted, 3freed, 4 free table full).
//   cfg  - writes heap_bytes (clamped to the heap size); taken only while idle,
//          it reloads the remaining byte count against the bump pointer.
// Sequencing: one command at a time through a sequencer that drives a
//   single shared adder; the next command is taken only after the last
//   one has moved its response into the output register. An allocate
//   searches the free table from the newest entry down; a match shifts the
//   newer entries down one place and drops the top entry, a miss carves a
//   fresh block or reports the heap exhausted. The search and removal
//   shift make one RAM access and one compare per step. A free pushes one
//   entry, or reports the table full.
// Reset: bump pointer and fill count clear, remaining bytes load the full
//   heap. Both RAMs hold garbage until written and need no clearing pass.
// Stall: a finished response sits in the output register; the sequencer
//   finishes the next command but holds it until that register frees up.
// ----------------------------------------------------------------------------
module exact_fit_free_list_allocator_core (
	input  logic       clk,
	input  logic       arst_n,
	efa_cmd_if.sink    cmd,
	efa_rsp_if.source  rsp,
	efa_cfg_if.sink    cfg
);

	localparam int OFF_W   = efa_pkg::OFF_W;
	localparam int ALU_W   = efa_pkg::ALU_W;
	localparam int HDR_AW  = efa_pkg::HDR_AW;
	localparam int FREE_AW = efa_pkg::FREE_AW;
	localparam int CNT_W   = efa_pkg::CNT_W;
	localparam int FREE_DW = efa_pkg::FREE_DW;

	typedef enum logic [12:0] {
		S_IDLE      = 13'b0000000000001,
		S_ROUND     = 13'b0000000000010,
		S_SRCH_ADDR = 13'b0000000000100,
		S_SRCH_CMP  = 13'b0000000001000,
		S_SHIFT_RD  = 13'b0000000010000,
		S_SHIFT_WR  = 13'b0000000100000,
		S_TOTAL     = 13'b0000001000000,
		S_FIT       = 13'b0000010000000,
		S_OFF       = 13'b0000100000000,
		S_BUMP      = 13'b0001000000000,
		S_FREE      = 13'b0010000000000,
		S_FPUSH     = 13'b0100000000000,
		S_DONE      = 13'b1000000000000
	} state_t;

	// sequencer state
	state_t              state_q, state_d;
	logic [OFF_W-1:0]    bump_q, bump_d;
	logic [OFF_W-1:0]    remaining_q, remaining_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [CNT_W-1:0]    idx_q, idx_d;        // next entry to search, plus one
	logic [CNT_W-1:0]    j_q, j_d;            // shift write pointer

	// per-command payload
	logic                is_free_q;
	logic [OFF_W-1:0]    req_q, boff_q;
	logic [ALU_W-1:0]    sz_q, sz_d;
	logic [ALU_W-1:0]    total_q, total_d;
	logic [OFF_W-1:0]    hit_off_q, hit_off_d;
	logic [OFF_W-1:0]    res_off_q, res_off_d;
	efa_pkg::status_t    res_st_q, res_st_d;

	// output register
	logic                out_valid_q;
	logic [OFF_W-1:0]    out_off_q;
	efa_pkg::status_t    out_st_q;
	logic                out_load;

	// shared unit
	efa_pkg::alu_req_t   alu_req;
	efa_pkg::alu_rsp_t   alu_rsp;

	// memories
	logic                free_we;
	logic [FREE_AW-1:0]  free_waddr, free_raddr;
	logic [FREE_DW-1:0]  free_wdata, free_rdata;
	logic [OFF_W-1:0]    ent_off, ent_size;
	logic                hdr_we;
	logic [HDR_AW-1:0]   hdr_waddr, hdr_raddr;
	logic [OFF_W-1:0]    hdr_wdata, hdr_rdata;

	logic                cmd_xfer, cfg_xfer;
	logic [OFF_W-1:0]    cfg_heap;
	logic [CNT_W-1:0]    j_next;

	efa_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	efa_ram #(.WIDTH(FREE_DW), .DEPTH(efa_pkg::FREE_DEPTH)) u_free_ram (
		.clk   (clk),
		.we    (free_we),
		.waddr (free_waddr),
		.wdata (free_wdata),
		.raddr (free_raddr),
		.rdata (free_rdata)
	);

	efa_ram #(.WIDTH(OFF_W), .DEPTH(efa_pkg::HEAP_WORDS)) u_hdr_ram (
		.clk   (clk),
		.we    (hdr_we),
		.waddr (hdr_waddr),
		.wdata (hdr_wdata),
		.raddr (hdr_raddr),
		.rdata (hdr_rdata)
	);

	assign ent_off  = free_rdata[FREE_DW-1:OFF_W];
	assign ent_size = free_rdata[OFF_W-1:0];
	assign j_next   = j_q + CNT_W'(1);

	// Commands and config writes are both taken only between commands.
	assign cmd.ready = (state_q == S_IDLE);
	assign cfg.ready = (state_q == S_IDLE);
	assign cmd_xfer  = cmd.valid && cmd.ready;
	assign cfg_xfer  = cfg.valid && cfg.ready;
	assign cfg_heap  = (cfg.data > efa_pkg::HEAP_CAP) ? efa_pkg::HEAP_CAP : cfg.data;

	// Hand the result over once the output register is empty or draining.
	assign out_load  = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	always_comb begin
		state_d     = state_q;
		bump_d      = bump_q;
		remaining_d = remaining_q;
		count_d     = count_q;
		idx_d       = idx_q;
		j_d         = j_q;
		sz_d        = sz_q;
		total_d     = total_q;
		hit_off_d   = hit_off_q;
		res_off_d   = res_off_q;
		res_st_d    = res_st_q;

		alu_req.op  = efa_pkg::ALU_ADD;
		alu_req.a   = '0;
		alu_req.b   = '0;

		free_we     = 1'b0;
		free_waddr  = j_q[FREE_AW-1:0];
		free_wdata  = free_rdata;
		free_raddr  = j_next[FREE_AW-1:0];
		hdr_we      = 1'b0;
		hdr_waddr   = bump_q[HDR_AW+1:2];
		hdr_wdata   = sz_q[OFF_W-1:0];
		hdr_raddr   = alu_rsp.y[HDR_AW-1:0];

		unique case (state_q)
			S_IDLE: begin
				// Reload remaining bytes: heap minus bump, floored at zero.
				alu_req.op = efa_pkg::ALU_SUB;
				alu_req.a  = ALU_W'(cfg_heap);
				alu_req.b  = ALU_W'(bump_q);
				if (cfg_xfer) begin
					remaining_d = alu_rsp.borrow ? '0 : alu_rsp.y[OFF_W-1:0];
				end
				if (cmd_xfer) begin
					state_d = (cmd.command == efa_pkg::CMD_FREE) ? S_FREE : S_ROUND;
				end
			end
			S_ROUND: begin
				// Round up to a word; a zero request becomes one word.
				alu_req.a = ALU_W'(req_q);
				alu_req.b = ALU_W'(3);
				sz_d      = {alu_rsp.y[ALU_W-1:2], 2'b00};
				if (alu_rsp.y[ALU_W-1:2] == '0) begin
					sz_d = ALU_W'(4);
				end
				idx_d   = count_q;
				state_d = S_SRCH_ADDR;
			end
			S_SRCH_ADDR: begin
				// Walk from the newest entry down; fall through to a carve.
				free_raddr = FREE_AW'(idx_q - CNT_W'(1));
				if (idx_q == '0) begin
					state_d = S_TOTAL;
				end else begin
					idx_d   = idx_q - CNT_W'(1);
					state_d = S_SRCH_CMP;
				end
			end
			S_SRCH_CMP: begin
				alu_req.op = efa_pkg::ALU_SUB;
				alu_req.a  = ALU_W'(ent_size);
				alu_req.b  = sz_q;
				if (alu_rsp.zero && !alu_rsp.borrow) begin
					hit_off_d = ent_off;
					j_d       = idx_q;
					state_d   = S_SHIFT_RD;
				end else begin
					state_d   = S_SRCH_ADDR;
				end
			end
			S_SHIFT_RD: begin
				// Close the gap one entry at a time, then drop the top entry.
				free_raddr = j_next[FREE_AW-1:0];
				if (j_next < count_q) begin
					state_d = S_SHIFT_WR;
				end else begin
					count_d   = count_q - CNT_W'(1);
					res_off_d = hit_off_q;
					res_st_d  = efa_pkg::ST_REUSED;
					state_d   = S_DONE;
				end
			end
			S_SHIFT_WR: begin
				free_we    = 1'b1;
				free_waddr = j_q[FREE_AW-1:0];
				free_wdata = free_rdata;
				j_d        = j_next;
				state_d    = S_SHIFT_RD;
			end
			S_TOTAL: begin
				alu_req.a = sz_q;
				alu_req.b = ALU_W'(4);
				total_d   = alu_rsp.y[ALU_W-1:0];
				state_d   = S_FIT;
			end
			S_FIT: begin
				alu_req.op = efa_pkg::ALU_SUB;
				alu_req.a  = ALU_W'(remaining_q);
				alu_req.b  = total_q;
				if (alu_rsp.borrow) begin
					res_off_d = '0;
					res_st_d  = efa_pkg::ST_EXHAUSTED;
					state_d   = S_DONE;
				end else begin
					remaining_d = alu_rsp.y[OFF_W-1:0];
					hdr_we      = 1'b1;
					state_d     = S_OFF;
				end
			end
			S_OFF: begin
				alu_req.a = ALU_W'(bump_q);
				alu_req.b = ALU_W'(4);
				res_off_d = alu_rsp.y[OFF_W-1:0];
				res_st_d  = efa_pkg::ST_FRESH;
				state_d   = S_BUMP;
			end
			S_BUMP: begin
				alu_req.a = ALU_W'(bump_q);
				alu_req.b = total_q;
				bump_d    = alu_rsp.y[OFF_W-1:0];
				state_d   = S_DONE;
			end
			S_FREE: begin
				// Header sits one word below the content, wrapped.
				alu_req.op = efa_pkg::ALU_SUB;
				alu_req.a  = ALU_W'(boff_q[OFF_W-1:2]);
				alu_req.b  = ALU_W'(1);
				if (count_q == CNT_W'(efa_pkg::FREE_DEPTH)) begin
					res_off_d = '0;
					res_st_d  = efa_pkg::ST_FULL;
					state_d   = S_DONE;
				end else begin
					state_d   = S_FPUSH;
				end
			end
			S_FPUSH: begin
				free_we    = 1'b1;
				free_waddr = count_q[FREE_AW-1:0];
				free_wdata = {boff_q, hdr_rdata};
				count_d    = count_q + CNT_W'(1);
				res_off_d  = '0;
				res_st_d   = efa_pkg::ST_FREED;
				state_d    = S_DONE;
			end
			S_DONE: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			bump_q      <= '0;
			remaining_q <= efa_pkg::HEAP_CAP;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			bump_q      <= bump_d;
			remaining_q <= remaining_d;
			count_q     <= count_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_xfer) begin
			is_free_q <= cmd.command;
			req_q     <= cmd.request_size;
			boff_q    <= cmd.block_offset;
		end
		idx_q     <= idx_d;
		j_q       <= j_d;
		sz_q      <= sz_d;
		total_q   <= total_d;
		hit_off_q <= hit_off_d;
		res_off_q <= res_off_d;
		res_st_q  <= res_st_d;
		if (out_load) begin
			out_off_q <= res_off_q;
			out_st_q  <= res_st_q;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.result_offset = out_off_q;
	assign rsp.status        = out_st_q;

	// A free command never reaches the allocate-only states.
	a_free_path: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ROUND || state_q == S_FIT) |-> !is_free_q)
		else $error("free command in allocate path");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(efa_pkg::FREE_DEPTH))
		else $error("free table count overflow");

	// Carved bytes plus remaining bytes never exceed the heap.
	a_heap_budget: assert property (@(posedge clk) disable iff (!arst_n)
		({2'b00, bump_q} + {2'b00, remaining_q}) <= {2'b00, efa_pkg::HEAP_CAP})
		else $error("bump pointer and remaining bytes exceed heap");

	a_full_status: assert property (@(posedge clk) disable iff (!arst_n)
		(out_load && res_st_q == efa_pkg::ST_FULL) |->
			count_q == CNT_W'(efa_pkg::FREE_DEPTH))
		else $error("table full reported with room left");

	a_fresh_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_st_q == efa_pkg::ST_FRESH) |-> out_off_q != '0)
		else $error("fresh block with zero offset");

	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_xfer |=> state_q != S_IDLE)
		else $error("command transfer did not start the sequencer");

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for exact_fit_free_list_allocator_core
// A table of directed commands runs first: fresh carves, reuse of the newest
// match, misaligned and wrapped frees, a double free, heap exhaustion, a
// full free table and the heap_bytes clamp. Four random phases follow, each
// with its own heap setting and idling mix. Every response is compared
// against a pinned table outcome or the model of bump, free table and headers.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int               OFF_W      = efa_pkg::OFF_W;
	localparam int               CNT_W      = efa_pkg::CNT_W;
	localparam int               FREE_DEPTH = efa_pkg::FREE_DEPTH;
	localparam int               HEAP_WORDS = efa_pkg::HEAP_WORDS;
	localparam logic [OFF_W-1:0] HEAP_CAP   = efa_pkg::HEAP_CAP;

	localparam int          CLK_PERIOD      = 10;
	localparam int          RESET_CYCLES    = 9;
	localparam int          PHASES          = 4;
	localparam int          ITEMS_PER_PHASE = 204;
	localparam int          LONG_HOLD       = 400;     // receiver hold-off, in cycles
	localparam int          TAIL_CYCLES     = 600;     // longest search plus margin
	localparam int unsigned CYCLE_LIMIT     = 4000000;
	localparam int          MAX_REPORTS     = 200;
	localparam int          DIR_ROWS        = 27;

	typedef efa_pkg::cmd_t    cmd_code_t;
	typedef efa_pkg::status_t status_t;

	localparam cmd_code_t CMD_ALLOC    = efa_pkg::CMD_ALLOC;
	localparam cmd_code_t CMD_FREE     = efa_pkg::CMD_FREE;
	localparam status_t   ST_FRESH     = efa_pkg::ST_FRESH;
	localparam status_t   ST_REUSED    = efa_pkg::ST_REUSED;
	localparam status_t   ST_EXHAUSTED = efa_pkg::ST_EXHAUSTED;
	localparam status_t   ST_FREED     = efa_pkg::ST_FREED;
	localparam status_t   ST_FULL      = efa_pkg::ST_FULL;

	typedef enum logic {
		ROW_CMD = 1'b0,
		ROW_CFG = 1'b1
	} row_kind_t;

	typedef struct packed {
		logic [OFF_W-1:0] offset;
		status_t          status;
	} outcome_t;

	// One directed step: a command repeated reps times, or a heap_bytes write.
	// Rows with pinned set carry their expected outcome; the rest use the model.
	typedef struct packed {
		row_kind_t        kind;
		cmd_code_t        cmd;
		logic [OFF_W-1:0] size_or_heap;
		logic [OFF_W-1:0] offset;
		logic [8:0]       reps;
		logic             pinned;
		logic [OFF_W-1:0] exp_offset;
		status_t          exp_status;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;

	efa_cmd_if cmd_ch ();
	efa_rsp_if rsp_ch ();
	efa_cfg_if cfg_ch ();

	exact_fit_free_list_allocator_core uut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------------
	// Allocator model: bump pointer, remaining bytes, free table, header store
	// ------------------------------------------------------------------------
	logic [OFF_W-1:0] heap_limit;
	logic [OFF_W-1:0] bump_ptr;
	logic [OFF_W-1:0] bytes_left;
	logic [OFF_W-1:0] tbl_off  [FREE_DEPTH];
	logic [OFF_W-1:0] tbl_size [FREE_DEPTH];
	logic [CNT_W-1:0] tbl_fill;
	logic [OFF_W-1:0] hdr_size [HEAP_WORDS];

	// Expected responses, oldest first, plus the block offsets the bench may
	// legally free: every fresh carve ever made, and the blocks still held.
	outcome_t         pending_outcomes [$];
	logic [OFF_W-1:0] carved_blocks [$];
	logic [OFF_W-1:0] held_blocks [$];

	int          n_errors      = 0;
	int          cmd_idle_pct  = 0;
	int          rsp_stall_pct = 0;
	int          hold_asked    = 0;
	int unsigned cycle_count   = 0;

	function automatic void apply_heap_write(input logic [OFF_W-1:0] v);
		// Clamp to the physical heap, then reload against the bump pointer.
		heap_limit = (v > HEAP_CAP) ? HEAP_CAP : v;
		bytes_left = (heap_limit > bump_ptr) ? heap_limit - bump_ptr : '0;
	endfunction

	function automatic outcome_t predict_outcome(input cmd_code_t op,
			input logic [OFF_W-1:0] size, input logic [OFF_W-1:0] off);
		int       need;
		int       total;
		int       k;
		int       j;
		int       hidx;
		outcome_t r;
		r.offset = '0;
		r.status = ST_FREED;
		if (op == CMD_ALLOC) begin
			need = (int'(size) + 3) & ~3;
			if (need == 0)
				need = 4;
			// Search newest first; a hit closes the gap by shifting down.
			for (k = int'(tbl_fill) - 1; k >= 0; k--) begin
				if (int'(tbl_size[k]) == need) begin
					r.offset = tbl_off[k];
					r.status = ST_REUSED;
					for (j = k; j + 1 < int'(tbl_fill); j++) begin
						tbl_off[j]  = tbl_off[j+1];
						tbl_size[j] = tbl_size[j+1];
					end
					tbl_fill = tbl_fill - 1'b1;
					return r;
				end
			end
			total = need + 4;
			if (int'(bytes_left) < total) begin
				r.status = ST_EXHAUSTED;
				return r;
			end
			hidx = int'(bump_ptr >> 2) % HEAP_WORDS;
			hdr_size[hidx] = OFF_W'(need);
			r.offset   = bump_ptr + OFF_W'(4);
			r.status   = ST_FRESH;
			bump_ptr   = bump_ptr + OFF_W'(total);
			bytes_left = bytes_left - OFF_W'(total);
		end else if (int'(tbl_fill) >= FREE_DEPTH) begin
			r.status = ST_FULL;
		end else begin
			// Header sits one word below the content, wrapped over the store.
			hidx = (int'(off >> 2) + HEAP_WORDS - 1) % HEAP_WORDS;
			tbl_off[tbl_fill]  = off;
			tbl_size[tbl_fill] = hdr_size[hidx];
			tbl_fill = tbl_fill + 1'b1;
		end
		return r;
	endfunction

	// ------------------------------------------------------------------------
	// Directed table
	// ------------------------------------------------------------------------
	dir_row_t dir_rows [DIR_ROWS] = '{
		// write above the cap: clamps back to the full heap
		'{ROW_CFG, CMD_ALLOC, 15'd32767, 15'd0,     9'd1,   1'b0, 15'd0,     ST_FRESH},
		// zero request is carved as 4 bytes; then 1 rounds to 4, 5 rounds to 8
		'{ROW_CMD, CMD_ALLOC, 15'd0,     15'd16383, 9'd1,   1'b1, 15'd4,     ST_FRESH},
		'{ROW_CMD, CMD_ALLOC, 15'd1,     15'd0,     9'd1,   1'b1, 15'd12,    ST_FRESH},
		'{ROW_CMD, CMD_ALLOC, 15'd5,     15'd21845, 9'd1,   1'b1, 15'd20,    ST_FRESH},
		'{ROW_CMD, CMD_FREE,  15'd16384, 15'd12,    9'd1,   1'b1, 15'd0,     ST_FREED},
		'{ROW_CMD, CMD_FREE,  15'd10922, 15'd4,     9'd1,   1'b1, 15'd0,     ST_FREED},
		// newest match wins, then the older one
		'{ROW_CMD, CMD_ALLOC, 15'd3,     15'd0,     9'd1,   1'b1, 15'd4,     ST_REUSED},
		'{ROW_CMD, CMD_ALLOC, 15'd4,     15'd0,     9'd1,   1'b1, 15'd12,    ST_REUSED},
		// misaligned free: header from the floor, offset kept as given
		'{ROW_CMD, CMD_FREE,  15'd0,     15'd21,    9'd1,   1'b1, 15'd0,     ST_FREED},
		'{ROW_CMD, CMD_ALLOC, 15'd8,     15'd0,     9'd1,   1'b1, 15'd21,    ST_REUSED},
		// double free pushes twice
		'{ROW_CMD, CMD_FREE,  15'd0,     15'd20,    9'd2,   1'b1, 15'd0,     ST_FREED},
		'{ROW_CMD, CMD_ALLOC, 15'd6,     15'd0,     9'd2,   1'b1, 15'd20,    ST_REUSED},
		// offset past the heap wraps onto the same header
		'{ROW_CMD, CMD_FREE,  15'd0,     15'd16404, 9'd1,   1'b1, 15'd0,     ST_FREED},
		'{ROW_CMD, CMD_ALLOC, 15'd7,     15'd0,     9'd1,   1'b1, 15'd16404, ST_REUSED},
		// largest request cannot fit behind the header
		'{ROW_CMD, CMD_ALLOC, 15'd16384, 15'd16384, 9'd1,   1'b1, 15'd0,     ST_EXHAUSTED},
		// smallest heap lies below the bump pointer: nothing left to carve
		'{ROW_CFG, CMD_ALLOC, 15'd8,     15'd0,     9'd1,   1'b0, 15'd0,     ST_FRESH},
		'{ROW_CMD, CMD_ALLOC, 15'd0,     15'd0,     9'd1,   1'b1, 15'd0,     ST_EXHAUSTED},
		'{ROW_CMD, CMD_FREE,  15'd0,     15'd4,     9'd1,   1'b1, 15'd0,     ST_FREED},
		'{ROW_CMD, CMD_ALLOC, 15'd2,     15'd0,     9'd1,   1'b1, 15'd4,     ST_REUSED},
		'{ROW_CFG, CMD_ALLOC, 15'd16384, 15'd0,     9'd1,   1'b0, 15'd0,     ST_FRESH},
		// fill the free table, overflow it once, then drain it
		'{ROW_CMD, CMD_FREE,  15'd0,     15'd4,     9'd256, 1'b1, 15'd0,     ST_FREED},
		'{ROW_CMD, CMD_FREE,  15'd0,     15'd12,    9'd1,   1'b1, 15'd0,     ST_FULL},
		'{ROW_CMD, CMD_ALLOC, 15'd1,     15'd0,     9'd256, 1'b1, 15'd4,     ST_REUSED},
		'{ROW_CMD, CMD_ALLOC, 15'd30,    15'd0,     9'd1,   1'b0, 15'd0,     ST_FRESH},
		'{ROW_CMD, CMD_FREE,  15'd0,     15'd32,    9'd1,   1'b0, 15'd0,     ST_FRESH},
		'{ROW_CMD, CMD_ALLOC, 15'd29,    15'd0,     9'd1,   1'b0, 15'd0,     ST_FRESH},
		'{ROW_CMD, CMD_ALLOC, 15'd16383, 15'd0,     9'd1,   1'b0, 15'd0,     ST_FRESH}
	};

	// ------------------------------------------------------------------------
	// Command sender
	// ------------------------------------------------------------------------
	// Offer one command, idling first at the phase's rate, and hold it until
	// the transfer. At the transfer, step the model and queue the outcome.
	task automatic send_cmd(input cmd_code_t op, input logic [OFF_W-1:0] size,
			input logic [OFF_W-1:0] off, input logic pinned, input outcome_t want);
		outcome_t got;
		while ($urandom_range(99) < cmd_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_ch.valid        <= 1'b1;
		cmd_ch.command      <= op;
		cmd_ch.request_size <= size;
		cmd_ch.block_offset <= off;
		do
			@(posedge clk);
		while (cmd_ch.ready !== 1'b1);
		got = predict_outcome(op, size, off);
		if (got.status == ST_FRESH)
			carved_blocks.push_back(got.offset);
		if (got.status == ST_FRESH || got.status == ST_REUSED)
			held_blocks.push_back(got.offset);
		pending_outcomes.push_back(pinned ? want : got);
	endtask

	// Write heap_bytes once the block is idle: command channel low, every
	// expected response already taken.
	task automatic write_heap(input logic [OFF_W-1:0] v);
		cmd_ch.valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= v;
		do
			@(posedge clk);
		while (cfg_ch.ready !== 1'b1);
		cfg_ch.valid <= 1'b0;
		apply_heap_write(v);
	endtask

	// Random command. Frees only name blocks whose header was carved: mostly
	// blocks still held, some double frees, some misaligned or wrapped
	// offsets of a carved block. Allocations are mostly small so the heap
	// lasts; the big ones are sized past what is left to force exhaustion.
	task automatic send_random();
		int               pick;
		int               idx;
		int               skew;
		logic [OFF_W-1:0] size;
		logic [OFF_W-1:0] off;
		pick = $urandom_range(99);
		size = OFF_W'($urandom_range(0, 16384));
		off  = OFF_W'($urandom_range(0, 16384));
		if (pick < 45 && carved_blocks.size() != 0) begin
			pick = $urandom_range(99);
			if (pick < 80 && held_blocks.size() != 0) begin
				idx = $urandom_range(0, held_blocks.size() - 1);
				off = held_blocks[idx];
				held_blocks.delete(idx);
			end else if (pick < 90) begin
				off = carved_blocks[$urandom_range(0, carved_blocks.size() - 1)];
			end else begin
				skew = $urandom_range(0, 3);
				off  = carved_blocks[$urandom_range(0, carved_blocks.size() - 1)]
					+ OFF_W'(skew);
				if (skew == 0 || $urandom_range(1) == 1)
					off = off + OFF_W'(16384);
			end
			send_cmd(CMD_FREE, size, off, 1'b0, '0);
		end else begin
			pick = $urandom_range(99);
			if (pick < 85)
				size = OFF_W'($urandom_range(0, 48));
			else if (pick < 95)
				size = OFF_W'($urandom_range(49, 512));
			else
				size = OFF_W'($urandom_range(int'(bytes_left), 16384));
			send_cmd(CMD_ALLOC, size, off, 1'b0, '0);
		end
	endtask

	// ------------------------------------------------------------------------
	// Response side
	// ------------------------------------------------------------------------
	// Drive ready: random stalls at the phase's rate, and a long hold-off
	// whenever the stimulus asks for one, so the block backs up into cmd.
	initial begin : rsp_ready_ctrl
		int held;
		held = 0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_asked != held) begin
				held = hold_asked;
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD - 1)
					@(posedge clk);
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
			end
		end
	end

	// Compare every response transfer with the oldest expected outcome.
	always @(posedge clk) begin : rsp_check
		outcome_t want;
		if (arst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			if (pending_outcomes.size() == 0) begin
				n_errors++;
				if (n_errors <= MAX_REPORTS)
					$display("%0t: unexpected response: expected none, actual offset %0d status %0d",
						$time, rsp_ch.result_offset, rsp_ch.status);
			end else begin
				want = pending_outcomes.pop_front();
				if (rsp_ch.result_offset !== want.offset) begin
					n_errors++;
					if (n_errors <= MAX_REPORTS)
						$display("%0t: result_offset mismatch: expected %0d, actual %0d",
							$time, want.offset, rsp_ch.result_offset);
				end
				if (rsp_ch.status !== want.status) begin
					n_errors++;
					if (n_errors <= MAX_REPORTS)
						$display("%0t: status mismatch: expected %0d, actual %0d",
							$time, want.status, rsp_ch.status);
				end
			end
		end
	end

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin : stimulus
		int       r;
		int       ph;
		outcome_t want;
		arst_n              = 1'b0;
		cmd_ch.valid        = 1'b0;
		cmd_ch.command      = CMD_ALLOC;
		cmd_ch.request_size = '0;
		cmd_ch.block_offset = '0;
		cfg_ch.valid        = 1'b0;
		cfg_ch.data         = '0;

		// Model state after reset: empty table, bump at zero, full heap.
		heap_limit = HEAP_CAP;
		bump_ptr   = '0;
		bytes_left = HEAP_CAP;
		tbl_fill   = '0;

		repeat (RESET_CYCLES)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table.
		for (r = 0; r < DIR_ROWS; r++) begin
			if (dir_rows[r].kind == ROW_CFG) begin
				write_heap(dir_rows[r].size_or_heap);
			end else begin
				want.offset = dir_rows[r].exp_offset;
				want.status = dir_rows[r].exp_status;
				repeat (dir_rows[r].reps)
					send_cmd(dir_rows[r].cmd, dir_rows[r].size_or_heap,
						dir_rows[r].offset, dir_rows[r].pinned, want);
			end
		end

		// Random phases, each with its own heap setting and idling mix.
		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin
					write_heap(OFF_W'(16384));
					cmd_idle_pct  = 0;
					rsp_stall_pct = 0;
					// start with a long receiver hold-off while commands keep coming
					hold_asked++;
				end
				1: begin
					write_heap(OFF_W'($urandom_range(8, 16384)));
					cmd_idle_pct  = 67;
					rsp_stall_pct = 0;
				end
				2: begin
					write_heap(OFF_W'($urandom_range(8, 16384)));
					cmd_idle_pct  = 0;
					rsp_stall_pct = 67;
				end
				default: begin
					write_heap(OFF_W'(32767));
					cmd_idle_pct  = 21;
					rsp_stall_pct = 21;
				end
			endcase
			repeat (ITEMS_PER_PHASE)
				send_random();
		end

		// Drain, then watch for stray responses a while longer.
		cmd_ch.valid <= 1'b0;
		while (pending_outcomes.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES)
			@(posedge clk);

		if (n_errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
